// File: hdl/cuc_pkg.sv
package cuc_pkg;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_SHORT  = 2'd1,
    ST_FORMAT = 2'd2,
    ST_LEVEL  = 2'd3
  } status_t;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_USER_EPOCH    = 1'b0,
    REG_AGENCY_OFFSET = 1'b1
  } cfg_idx_t;

  localparam int CFG_IDX_W = 1;

  localparam logic MODE_DECODE = 1'b0;
  localparam logic MODE_ENCODE = 1'b1;
  localparam logic KIND_DECODE = 1'b0;
  localparam logic KIND_ENCODE = 1'b1;

  localparam logic [7:0] PRE_EXT_MASK = 8'h80;
  localparam logic [2:0] LEVEL_AGENCY = 3'd1;
  localparam logic [2:0] LEVEL_USER   = 3'd2;
  localparam logic [3:0] MAX_SEEN     = 4'd8;

  // Per-beat decode result handed to the top level
  typedef struct packed {
    logic        report;
    status_t     status;
    logic        user_lvl;
    logic [31:0] coarse;
    logic [31:0] fine;
  } dec_res_t;

  function automatic logic [2:0] pre_level(input logic [7:0] pre);
    pre_level = pre[6:4];
  endfunction

  // coarse octet count, 1..4
  function automatic logic [2:0] pre_coarse(input logic [7:0] pre);
    pre_coarse = {1'b0, pre[3:2]} + 3'd1;
  endfunction

  // preamble check against available length
  function automatic status_t check_code(input logic [7:0] pre, input logic [7:0] len);
    logic [2:0] lvl;
    logic [3:0] need;
    status_t    st;
    lvl  = pre_level(pre);
    need = 4'd1 + {1'b0, pre_coarse(pre)} + {2'b00, pre[1:0]};
    if (len < 8'd2) begin
      st = ST_SHORT;
    end else if ((pre & PRE_EXT_MASK) != 8'h00) begin
      st = ST_FORMAT;
    end else if (!(lvl inside {LEVEL_AGENCY, LEVEL_USER})) begin
      st = ST_LEVEL;
    end else if (len < {4'b0000, need}) begin
      st = ST_SHORT;
    end else begin
      st = ST_OK;
    end
    check_code = st;
  endfunction

endpackage

// File: hdl/cuc_time_code_codec_unit.sv
// CUC time code codec: holds signed seconds plus a 32-bit binary fraction and
// converts it to and from the unsegmented time code.
// Input channel (in_valid / in_stall): one beat is either a received code byte
// (in_mode = 0, in_last_in on the final byte) or an encode request
// (in_mode = 1, preamble in in_data_byte, room in in_buffer_size).
// Result channel (out_valid / out_stall): a decode beat gives one status result
// only on in_last_in; an encode request gives the preamble and its coarse and
// fine bytes (2 to 8 results), or one error result.
// Config channel (cfg_valid / cfg_ready, always ready): index 0 user epoch,
// index 1 agency epoch offset; write only while the block is idle.
// Each result is registered and appears on the port from the output register.
// Throughput: one decode byte per cycle while in_stall is low; an encode
// request holds in_stall until its byte shifter has drained.
// Reset (synchronous, rst_n low) clears the stored time, the offsets, the
// decode assembly state, the shifter count and the output valid flag.
// While out_stall is high with a result held, the result holds and in_stall
// rises, so nothing is lost or repeated.
module cuc_time_code_codec_unit
  import cuc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // input channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_mode,
  input  logic [7:0]           in_data_byte,
  input  logic                 in_last_in,
  input  logic [7:0]           in_buffer_size,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_kind,
  output logic [1:0]           out_status,
  output logic [7:0]           out_code_byte,
  output logic                 out_last_out,
  output logic signed [63:0]   out_time_seconds,
  output logic [31:0]          out_time_fraction,
  // config channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic signed [63:0]   cfg_data
);

  // offsets
  logic signed [63:0] user_epoch_r;
  logic signed [63:0] agency_r;

  // stored time
  logic signed [63:0] sec_r, sec_nxt;
  logic [31:0]        frac_r, frac_nxt;

  // output register
  logic               out_valid_r, out_valid_nxt;
  logic               out_kind_r, out_kind_nxt;
  status_t            out_status_r, out_status_nxt;
  logic [7:0]         out_byte_r, out_byte_nxt;
  logic               out_last_r, out_last_nxt;
  logic signed [63:0] out_sec_r, out_sec_nxt;
  logic [31:0]        out_frac_r, out_frac_nxt;

  // encode byte shifter: top byte goes next
  logic [2:0]         rem_r, rem_nxt;
  logic [55:0]        emit_r, emit_nxt;

  logic     out_free;
  logic     in_beat;
  logic     dec_beat;
  logic     enc_beat;
  dec_res_t dec_res;

  status_t            enc_status;
  logic [2:0]         enc_c;
  logic [3:0]         enc_total;
  logic signed [63:0] enc_secs;
  logic [31:0]        enc_cw;
  logic [55:0]        enc_seq;
  logic [1:0]         enc_pad;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (rem_r != 3'd0) || !out_free;
  assign in_beat  = in_valid && !in_stall;
  assign dec_beat = in_beat && (in_mode == MODE_DECODE);
  assign enc_beat = in_beat && (in_mode == MODE_ENCODE);

  cuc_decoder u_dec (
    .clk       (clk),
    .rst_n     (rst_n),
    .beat      (dec_beat),
    .data_byte (in_data_byte),
    .last_in   (in_last_in),
    .res       (dec_res)
  );

  // encode: time back on the code epoch, bytes lined up for the shifter
  assign enc_status = check_code(in_data_byte, in_buffer_size);
  assign enc_c      = pre_coarse(in_data_byte);
  assign enc_total  = 4'd1 + {1'b0, enc_c} + {2'b00, in_data_byte[1:0]};
  assign enc_secs   = sec_r - agency_r
                    - ((pre_level(in_data_byte) == LEVEL_USER) ? user_epoch_r : 64'sd0);
  assign enc_pad    = 2'(3'd4 - enc_c);
  assign enc_cw     = enc_secs[31:0] << {enc_pad, 3'b000};
  assign enc_seq    = {enc_cw, 24'h000000} | ({frac_r[31:8], 32'h0} >> {enc_c, 3'b000});

  always_comb begin
    sec_nxt        = sec_r;
    frac_nxt       = frac_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_kind_nxt   = out_kind_r;
    out_status_nxt = out_status_r;
    out_byte_nxt   = out_byte_r;
    out_last_nxt   = out_last_r;
    out_sec_nxt    = out_sec_r;
    out_frac_nxt   = out_frac_r;
    rem_nxt        = rem_r;
    emit_nxt       = emit_r;

    if (dec_beat && dec_res.report) begin
      if (dec_res.status == ST_OK) begin
        sec_nxt  = {32'h0, dec_res.coarse} + agency_r
                 + (dec_res.user_lvl ? user_epoch_r : 64'sd0);
        frac_nxt = dec_res.fine;
      end
      out_valid_nxt  = 1'b1;
      out_kind_nxt   = KIND_DECODE;
      out_status_nxt = dec_res.status;
      out_byte_nxt   = 8'h00;
      out_last_nxt   = 1'b1;
      out_sec_nxt    = sec_nxt;
      out_frac_nxt   = frac_nxt;
    end else if (enc_beat) begin
      out_valid_nxt  = 1'b1;
      out_kind_nxt   = KIND_ENCODE;
      out_status_nxt = enc_status;
      out_sec_nxt    = sec_r;
      out_frac_nxt   = frac_r;
      if (enc_status != ST_OK) begin
        out_byte_nxt = 8'h00;
        out_last_nxt = 1'b1;
      end else begin
        out_byte_nxt = in_data_byte;
        out_last_nxt = (enc_total == 4'd1);
        rem_nxt      = 3'(enc_total - 4'd1);
        emit_nxt     = enc_seq;
      end
    end else if ((rem_r != 3'd0) && out_free) begin
      out_valid_nxt  = 1'b1;
      out_kind_nxt   = KIND_ENCODE;
      out_status_nxt = ST_OK;
      out_byte_nxt   = emit_r[55:48];
      out_last_nxt   = (rem_r == 3'd1);
      out_sec_nxt    = sec_r;
      out_frac_nxt   = frac_r;
      rem_nxt        = rem_r - 3'd1;
      emit_nxt       = {emit_r[47:0], 8'h00};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      user_epoch_r <= '0;
      agency_r     <= '0;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        REG_USER_EPOCH:    user_epoch_r <= cfg_data;
        REG_AGENCY_OFFSET: agency_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sec_r       <= '0;
      frac_r      <= '0;
      out_valid_r <= 1'b0;
      rem_r       <= '0;
    end else begin
      sec_r       <= sec_nxt;
      frac_r      <= frac_nxt;
      out_valid_r <= out_valid_nxt;
      rem_r       <= rem_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    out_kind_r   <= out_kind_nxt;
    out_status_r <= out_status_nxt;
    out_byte_r   <= out_byte_nxt;
    out_last_r   <= out_last_nxt;
    out_sec_r    <= out_sec_nxt;
    out_frac_r   <= out_frac_nxt;
    emit_r       <= emit_nxt;
  end

  assign cfg_ready         = 1'b1;
  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_status        = out_status_r;
  assign out_code_byte     = out_byte_r;
  assign out_last_out      = out_last_r;
  assign out_time_seconds  = out_sec_r;
  assign out_time_fraction = out_frac_r;

endmodule

// File: hdl/cuc_decoder.sv
// Assembles a received code one byte per beat.
module cuc_decoder
  import cuc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       beat,
  input  logic [7:0] data_byte,
  input  logic       last_in,
  output dec_res_t   res
);

  logic [3:0]  seen_r, seen_nxt;
  logic [7:0]  pre_r, pre_nxt;
  logic [31:0] coarse_r, coarse_nxt;
  logic [31:0] fine_r, fine_nxt;

  logic [2:0] c_len;
  logic [2:0] cf_len;
  logic [3:0] fine_idx;

  assign c_len    = pre_coarse(pre_r);
  assign cf_len   = c_len + {1'b0, pre_r[1:0]};
  assign fine_idx = seen_r - 4'd1 - {1'b0, c_len};

  always_comb begin
    seen_nxt   = seen_r;
    pre_nxt    = pre_r;
    coarse_nxt = coarse_r;
    fine_nxt   = fine_r;
    if (seen_r < MAX_SEEN) begin
      if (seen_r == 4'd0) begin
        pre_nxt    = data_byte;
        coarse_nxt = '0;
        fine_nxt   = '0;
      end else if (seen_r <= {1'b0, c_len}) begin
        coarse_nxt = {coarse_r[23:0], data_byte};
      end else if (seen_r <= {1'b0, cf_len}) begin
        // fine bytes fill from the top byte down
        fine_nxt = fine_r | ({data_byte, 24'h000000} >> {fine_idx[1:0], 3'b000});
      end
      seen_nxt = seen_r + 4'd1;
    end
    res.report   = last_in;
    res.status   = check_code(pre_nxt, {4'b0000, seen_nxt});
    res.user_lvl = (pre_level(pre_nxt) == LEVEL_USER);
    res.coarse   = coarse_nxt;
    res.fine     = fine_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r   <= '0;
      pre_r    <= '0;
      coarse_r <= '0;
      fine_r   <= '0;
    end else if (beat) begin
      if (last_in) begin
        seen_r   <= '0;
        pre_r    <= '0;
        coarse_r <= '0;
        fine_r   <= '0;
      end else begin
        seen_r   <= seen_nxt;
        pre_r    <= pre_nxt;
        coarse_r <= coarse_nxt;
        fine_r   <= fine_nxt;
      end
    end
  end

endmodule

// File: hdl/cuc_checker.sv
module cuc_checker
  import cuc_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic               out_kind,
  input logic [1:0]         out_status,
  input logic [7:0]         out_code_byte,
  input logic               out_last_out,
  input logic signed [63:0] out_time_seconds
);

  // held result does not change under stall
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_code_byte)
                                && $stable(out_last_out))
    else $error("stalled result changed");

  // decode reports and errors are single, byte-free results
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_DECODE || out_status != ST_OK)
    |-> out_last_out && out_code_byte == 8'h00)
    else $error("report or error not final or carries a byte");

  // an encode burst continues next cycle with the same time
  a_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_kind == KIND_ENCODE && !out_last_out
    |=> out_valid && out_kind == KIND_ENCODE && $stable(out_time_seconds))
    else $error("encode burst broken");

  // no new input while a burst is in flight
  a_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_ENCODE && !out_last_out |-> in_stall)
    else $error("input taken mid burst");

endmodule

bind cuc_time_code_codec_unit cuc_checker u_cuc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_kind         (out_kind),
  .out_status       (out_status),
  .out_code_byte    (out_code_byte),
  .out_last_out     (out_last_out),
  .out_time_seconds (out_time_seconds)
);
